@@ hw/rtl/fpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared constants, types and CRC helper for the firmware package checker.
// ----------------------------------------------------------------------------
package fpsc_pkg;

    localparam int WRITE_BYTES_DEF = 8;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [15:0] APP_ID   = 16'hA501;
    localparam logic [15:0] SIG_ID   = 16'h5A02;
    localparam logic [3:0]  HDR_LEN  = 4'd10;
    localparam logic [31:0] SIG_LEN  = 32'd256;
    localparam logic [31:0] MIN_PKG  = 32'd276;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_FINAL = 2'd2;

    localparam logic [1:0] CFG_PKG_LEN  = 2'd0;
    localparam logic [1:0] CFG_TARGET   = 2'd1;
    localparam logic [1:0] CFG_RSTART   = 2'd2;
    localparam logic [1:0] CFG_RSIZE    = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_STATE      = 3'd1;
    localparam logic [2:0] ST_FORMAT     = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_CHECKSUM   = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_APP_HDR  = 6'b000010,
        PH_APP_DATA = 6'b000100,
        PH_SIG_HDR  = 6'b001000,
        PH_SIG_DATA = 6'b010000,
        PH_FAILED   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        write_valid;
        logic [31:0] flash_address;
        logic [63:0] write_data;
        logic [3:0]  write_count;
        logic        image_accepted;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Request [addr, addr+size) must lie in region and not pass 2^32.
    function automatic logic in_region(input logic [31:0] addr, input logic [32:0] size,
                                       input logic [31:0] rstart, input logic [31:0] rsize);
        logic [33:0] req_end;
        logic [33:0] reg_end;
        req_end = {1'b0, addr} + {1'b0, size};
        reg_end = {2'b0, rstart} + {2'b0, rsize};
        return (size != 33'd0) && (req_end <= 34'h1_0000_0000) && (addr >= rstart)
               && (req_end <= reg_end);
    endfunction

endpackage

@@ hw/rtl/fpsc_core.sv @@
// ----------------------------------------------------------------------------
// fpsc_core
// Session state and the single-pass next-state and result logic per word.
// ----------------------------------------------------------------------------
module fpsc_core #(
    parameter int WRITE_BYTES = fpsc_pkg::WRITE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        action,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       package_length,
    input  logic [31:0]       target_base,
    input  logic [31:0]       region_start,
    input  logic [31:0]       region_size,
    output fpsc_pkg::result_t result,
    output fpsc_pkg::phase_t  phase
);
    localparam int PW = $clog2(WRITE_BYTES + 1);
    localparam logic [PW-1:0] WB = PW'(WRITE_BYTES);
    localparam logic [32:0]   WB33 = 33'(WRITE_BYTES);
    localparam int WB_TZ  = (WRITE_BYTES % 8 == 0) ? 3 : (WRITE_BYTES % 4 == 0) ? 2
                          : (WRITE_BYTES % 2 == 0) ? 1 : 0;
    localparam int WB_ODD = WRITE_BYTES >> WB_TZ;
    localparam int WB_DIG = (WB_ODD == 5) ? 4 : (WB_ODD == 7) ? 3 : 2;

    fpsc_pkg::phase_t phase_reg, phase_next;
    logic [79:0] hdr_reg, hdr_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [31:0] app_len_reg, app_len_next, app_exp_reg, app_exp_next;
    logic [31:0] sig_exp_reg, sig_exp_next, pkg_cnt_reg, pkg_cnt_next;
    logic [31:0] app_cnt_reg, app_cnt_next, wr_cnt_reg, wr_cnt_next;
    logic [63:0] pend_reg, pend_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    logic [31:0] app_crc_reg, app_crc_next, sig_crc_reg, sig_crc_next;
    logic [8:0]  sig_cnt_reg, sig_cnt_next;

    // Size modulo WRITE_BYTES: keep the low power-of-two bits and reduce the
    // rest modulo the odd factor by summing digits whose weight is 1 mod it.
    function automatic logic [3:0] size_rem(input logic [31:0] v);
        logic [31:0] q;
        logic [7:0]  acc;
        logic [7:0]  nxt;
        logic [3:0]  lo;
        q   = v >> WB_TZ;
        lo  = 4'(v & ((32'd1 << WB_TZ) - 32'd1));
        acc = 8'd0;
        for (int i = 0; i < 32; i += WB_DIG)
            acc = acc + 8'((q >> i) & ((32'd1 << WB_DIG) - 32'd1));
        for (int r = 0; r < 2; r++)
        begin
            nxt = 8'd0;
            for (int i = 0; i < 8; i += WB_DIG)
                nxt = nxt + 8'((acc >> i) & ((8'd1 << WB_DIG) - 8'd1));
            acc = nxt;
        end
        for (int r = 0; r < 3; r++)
            if (acc >= 8'(WB_ODD)) acc = acc - 8'(WB_ODD);
        if (WB_ODD == 1) acc = 8'd0;
        return 4'((acc << WB_TZ) | 8'(lo));
    endfunction

    assign phase = phase_reg;

    always_comb
    begin
        logic [79:0] h;
        logic [31:0] sz;
        logic [32:0] aligned;
        logic [32:0] rem;
        logic [2:0]  st;
        logic        emit, active;
        logic [63:0] pw;
        phase_next = phase_reg; hdr_next = hdr_reg; hcnt_next = hcnt_reg;
        app_len_next = app_len_reg; app_exp_next = app_exp_reg; sig_exp_next = sig_exp_reg;
        pkg_cnt_next = pkg_cnt_reg; app_cnt_next = app_cnt_reg; wr_cnt_next = wr_cnt_reg;
        pend_next = pend_reg; pcnt_next = pcnt_reg; app_crc_next = app_crc_reg;
        sig_crc_next = sig_crc_reg; sig_cnt_next = sig_cnt_reg;
        result = '0;
        st = fpsc_pkg::ST_OK;
        emit = 1'b0;
        pw = pend_reg;
        h = hdr_reg;
        sz = 32'd0; aligned = 33'd0; rem = 33'd0;
        active = (phase_reg == fpsc_pkg::PH_APP_HDR) || (phase_reg == fpsc_pkg::PH_APP_DATA)
              || (phase_reg == fpsc_pkg::PH_SIG_HDR) || (phase_reg == fpsc_pkg::PH_SIG_DATA);
        if (action == fpsc_pkg::ACT_START) begin
            hdr_next = '0; hcnt_next = '0; app_len_next = '0; app_exp_next = '0;
            sig_exp_next = '0; pkg_cnt_next = '0; app_cnt_next = '0; wr_cnt_next = '0;
            pend_next = '0; pcnt_next = '0; app_crc_next = fpsc_pkg::CRC_INIT;
            sig_crc_next = fpsc_pkg::CRC_INIT; sig_cnt_next = '0;
            if (package_length < fpsc_pkg::MIN_PKG
                || !fpsc_pkg::in_region(target_base, WB33, region_start, region_size)) begin
                st = fpsc_pkg::ST_FORMAT;
                phase_next = fpsc_pkg::PH_IDLE;
            end else begin
                phase_next = fpsc_pkg::PH_APP_HDR;
            end
        end else if (action == fpsc_pkg::ACT_BYTE && active) begin
            if (pkg_cnt_reg >= package_length) begin
                st = fpsc_pkg::ST_FORMAT;
            end else begin
                pkg_cnt_next = pkg_cnt_reg + 32'd1;
                if (phase_reg == fpsc_pkg::PH_APP_HDR || phase_reg == fpsc_pkg::PH_SIG_HDR)
                begin
                    h[hcnt_reg*8 +: 8] = data_byte;
                    hdr_next = h;
                    if (hcnt_reg != fpsc_pkg::HDR_LEN - 4'd1) begin
                        hcnt_next = hcnt_reg + 4'd1;
                    end else begin
                        hcnt_next = '0;
                        if (phase_reg == fpsc_pkg::PH_APP_HDR) begin
                            sz = h[47:16];
                            rem = 33'(size_rem(sz));
                            aligned = {1'b0, sz} + ((rem == 33'd0) ? 33'd0 : (WB33 - rem));
                            if (h[15:0] != fpsc_pkg::APP_ID) begin
                                st = fpsc_pkg::ST_FORMAT;
                            end else begin
                                app_len_next = sz;
                                app_exp_next = h[79:48];
                                if (!fpsc_pkg::in_region(target_base, aligned,
                                                         region_start, region_size)
                                    || ({1'b0, sz} + 33'd276 != {1'b0, package_length}))
                                    st = fpsc_pkg::ST_FORMAT;
                                else
                                    phase_next = fpsc_pkg::PH_APP_DATA;
                            end
                        end else begin
                            if (h[15:0] != fpsc_pkg::SIG_ID || h[47:16] != fpsc_pkg::SIG_LEN)
                                st = fpsc_pkg::ST_FORMAT;
                            else begin
                                sig_exp_next = h[79:48];
                                sig_cnt_next = '0;
                                phase_next = fpsc_pkg::PH_SIG_DATA;
                            end
                        end
                    end
                end else if (phase_reg == fpsc_pkg::PH_APP_DATA) begin
                    if (app_cnt_reg >= app_len_reg || pcnt_reg >= WB) begin
                        st = fpsc_pkg::ST_FORMAT;
                    end else begin
                        pw[pcnt_reg*8 +: 8] = data_byte;
                        pend_next = pw;
                        pcnt_next = pcnt_reg + PW'(1);
                        app_cnt_next = app_cnt_reg + 32'd1;
                        app_crc_next = fpsc_pkg::crc_byte(app_crc_reg, data_byte);
                        if (pcnt_next == WB) emit = 1'b1;
                        if (app_cnt_next == app_len_reg) phase_next = fpsc_pkg::PH_SIG_HDR;
                    end
                end else begin
                    if ({23'd0, sig_cnt_reg} >= fpsc_pkg::SIG_LEN)
                        st = fpsc_pkg::ST_FORMAT;
                    else begin
                        sig_cnt_next = sig_cnt_reg + 9'd1;
                        sig_crc_next = fpsc_pkg::crc_byte(sig_crc_reg, data_byte);
                    end
                end
            end
            if (st != fpsc_pkg::ST_OK) phase_next = fpsc_pkg::PH_FAILED;
        end else if (action == fpsc_pkg::ACT_FINAL && active) begin
            if (pkg_cnt_reg != package_length || phase_reg != fpsc_pkg::PH_SIG_DATA
                || {23'd0, sig_cnt_reg} != fpsc_pkg::SIG_LEN || app_cnt_reg != app_len_reg)
                st = fpsc_pkg::ST_INCOMPLETE;
            else begin
                emit = (pcnt_reg != '0);
                if (~sig_crc_reg != sig_exp_reg || ~app_crc_reg != app_exp_reg)
                    st = fpsc_pkg::ST_CHECKSUM;
                else begin
                    result.image_accepted = 1'b1;
                    phase_next = fpsc_pkg::PH_IDLE;
                end
            end
            if (st != fpsc_pkg::ST_OK) phase_next = fpsc_pkg::PH_FAILED;
        end else begin
            st = fpsc_pkg::ST_STATE;
        end
        if (emit) begin
            result.write_valid   = 1'b1;
            result.flash_address = target_base + wr_cnt_reg;
            result.write_data    = pw;
            result.write_count   = 4'(pcnt_next == WB ? WB : pcnt_reg);
            wr_cnt_next = wr_cnt_reg + 32'(result.write_count);
            pend_next = '0;
            pcnt_next = '0;
        end
        result.status = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= fpsc_pkg::PH_IDLE;
            hdr_reg <= '0; hcnt_reg <= '0; app_len_reg <= '0; app_exp_reg <= '0;
            sig_exp_reg <= '0; pkg_cnt_reg <= '0; app_cnt_reg <= '0; wr_cnt_reg <= '0;
            pend_reg <= '0; pcnt_reg <= '0; app_crc_reg <= fpsc_pkg::CRC_INIT;
            sig_crc_reg <= fpsc_pkg::CRC_INIT; sig_cnt_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            hdr_reg <= hdr_next; hcnt_reg <= hcnt_next; app_len_reg <= app_len_next;
            app_exp_reg <= app_exp_next; sig_exp_reg <= sig_exp_next;
            pkg_cnt_reg <= pkg_cnt_next; app_cnt_reg <= app_cnt_next;
            wr_cnt_reg <= wr_cnt_next; pend_reg <= pend_next; pcnt_reg <= pcnt_next;
            app_crc_reg <= app_crc_next; sig_crc_reg <= sig_crc_next;
            sig_cnt_reg <= sig_cnt_next;
        end
    end
endmodule

@@ hw/rtl/firmware_package_stream_checker.sv @@
// ----------------------------------------------------------------------------
// firmware_package_stream_checker
// Checks a streamed firmware package and issues aligned flash write words.
// ----------------------------------------------------------------------------
// One word (an action plus a byte) is taken and answered by one result:
// it passes an input register, then the single-pass check, CRC-32 byte
// step and word packing into the result register. With the output drained,
// throughput is one word per clock; the CRC byte step in the core sets the
// clock period. Write the four configuration registers only while no words
// are in flight.
module firmware_package_stream_checker #(
    parameter int WRITE_BYTES = fpsc_pkg::WRITE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        write_valid,
    output logic [31:0] flash_address,
    output logic [63:0] write_data,
    output logic [3:0]  write_count,
    output logic        image_accepted,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] pkg_len_reg, target_reg, rstart_reg, rsize_reg;
    logic        iv_reg;
    logic [1:0]  act_reg;
    logic [7:0]  byte_reg;
    logic        ov_reg;
    fpsc_pkg::result_t res_reg, res_comb;
    fpsc_pkg::phase_t  phase;
    logic        step;

    // Advance the core when the result slot is free or being drained.
    assign step     = iv_reg && (!ov_reg || out_ready);
    assign in_ready = !iv_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pkg_len_reg <= '0; target_reg <= '0; rstart_reg <= '0; rsize_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                fpsc_pkg::CFG_PKG_LEN: pkg_len_reg <= cfg_data;
                fpsc_pkg::CFG_TARGET:  target_reg  <= cfg_data;
                fpsc_pkg::CFG_RSTART:  rstart_reg  <= cfg_data;
                fpsc_pkg::CFG_RSIZE:   rsize_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (in_ready) iv_reg <= in_valid;
            if (step) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            act_reg  <= action;
            byte_reg <= data_byte;
        end
        if (step) res_reg <= res_comb;
    end

    fpsc_core #(.WRITE_BYTES(WRITE_BYTES)) u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .action(act_reg), .data_byte(byte_reg),
        .package_length(pkg_len_reg), .target_base(target_reg),
        .region_start(rstart_reg), .region_size(rsize_reg),
        .result(res_comb), .phase(phase)
    );

    assign out_valid      = ov_reg;
    assign status         = res_reg.status;
    assign write_valid    = res_reg.write_valid;
    assign flash_address  = res_reg.flash_address;
    assign write_data     = res_reg.write_data;
    assign write_count    = res_reg.write_count;
    assign image_accepted = res_reg.image_accepted;

    // A result is held while the sink stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg))
        else $error("result changed under stall");
    // An accepted image always leaves the session idle.
    a_acc: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_comb.image_accepted |=> phase == fpsc_pkg::PH_IDLE)
        else $error("accept without idle");
    // A write never carries more than one word of bytes.
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_valid |-> write_count != 4'd0
                                     && 32'(write_count) <= 32'(WRITE_BYTES))
        else $error("bad write count");
endmodule

@@ verif/fpsc_result_checker.sv @@
// ----------------------------------------------------------------------------
// fpsc_result_checker
// Watches both word channels and the register port of the package checker,
// predicts every result from its own copy of the session state and compares
// each returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fpsc_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic        write_valid,
    input  logic [31:0] flash_address,
    input  logic [63:0] write_data,
    input  logic [3:0]  write_count,
    input  logic        image_accepted,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BYTES = fpsc_pkg::WRITE_BYTES_DEF;

    logic [31:0] pkg_len, target, region_start, region_size;

    fpsc_pkg::phase_t phase;
    logic [7:0]  hdr_bytes [10];
    int          hdr_count;
    logic [31:0] app_len, app_crc_exp, sig_crc_exp;
    logic [31:0] pkg_count, app_count, written;
    logic [63:0] pend_word;
    int          pend_cnt;
    logic [31:0] app_crc, sig_crc;
    int          sig_count;

    fpsc_pkg::result_t expected_q [$];

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 32'hEDB8_8320;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [31:0] hdr_word(input int at);
        return {hdr_bytes[at + 3], hdr_bytes[at + 2], hdr_bytes[at + 1], hdr_bytes[at]};
    endfunction

    // Request end computed in 64 bits: no wrap, must stay at or below 2^32.
    function automatic bit fits(input logic [31:0] addr, input logic [63:0] size);
        logic [63:0] req_end;
        req_end = 64'(addr) + size;
        return size != 0 && req_end <= 64'h1_0000_0000 && addr >= region_start
               && req_end <= 64'(region_start) + 64'(region_size);
    endfunction

    task automatic clear_session();
        foreach (hdr_bytes[k])
            hdr_bytes[k] = 8'd0;
        hdr_count   = 0;
        app_len     = 0;
        app_crc_exp = 0;
        sig_crc_exp = 0;
        pkg_count   = 0;
        app_count   = 0;
        written     = 0;
        pend_word   = 0;
        pend_cnt    = 0;
        app_crc     = fpsc_pkg::CRC_INIT;
        sig_crc     = fpsc_pkg::CRC_INIT;
        sig_count   = 0;
        phase       = fpsc_pkg::PH_IDLE;
    endtask

    task automatic flush_word(inout fpsc_pkg::result_t r);
        r.write_valid   = 1'b1;
        r.flash_address = target + written;
        r.write_data    = pend_word;
        r.write_count   = 4'(pend_cnt);
        written        += pend_cnt;
        pend_word       = 0;
        pend_cnt        = 0;
    endtask

    task automatic take_byte(input logic [7:0] b, inout fpsc_pkg::result_t r,
                             output logic [2:0] st);
        logic [63:0] aligned;
        st = fpsc_pkg::ST_OK;
        if (pkg_count >= pkg_len)
        begin
            st = fpsc_pkg::ST_FORMAT;
            return;
        end
        pkg_count++;
        if (phase == fpsc_pkg::PH_APP_HDR || phase == fpsc_pkg::PH_SIG_HDR)
        begin
            hdr_bytes[hdr_count] = b;
            hdr_count++;
            if (hdr_count < 10)
                return;
            hdr_count = 0;
            if (phase == fpsc_pkg::PH_APP_HDR)
            begin
                if ({hdr_bytes[1], hdr_bytes[0]} != fpsc_pkg::APP_ID)
                begin
                    st = fpsc_pkg::ST_FORMAT;
                    return;
                end
                app_len     = hdr_word(2);
                app_crc_exp = hdr_word(6);
                aligned     = (64'(app_len) + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
                if (!fits(target, aligned) || 64'd276 + 64'(app_len) != 64'(pkg_len))
                begin
                    st = fpsc_pkg::ST_FORMAT;
                    return;
                end
                phase = fpsc_pkg::PH_APP_DATA;
            end
            else
            begin
                if ({hdr_bytes[1], hdr_bytes[0]} != fpsc_pkg::SIG_ID
                    || hdr_word(2) != fpsc_pkg::SIG_LEN)
                begin
                    st = fpsc_pkg::ST_FORMAT;
                    return;
                end
                sig_crc_exp = hdr_word(6);
                sig_count   = 0;
                phase       = fpsc_pkg::PH_SIG_DATA;
            end
            return;
        end
        if (phase == fpsc_pkg::PH_APP_DATA)
        begin
            if (app_count >= app_len || pend_cnt >= WORD_BYTES)
            begin
                st = fpsc_pkg::ST_FORMAT;
                return;
            end
            pend_word |= 64'(b) << (8 * pend_cnt);
            pend_cnt++;
            app_count++;
            app_crc = crc_step(app_crc, b);
            if (pend_cnt == WORD_BYTES)
                flush_word(r);
            if (app_count == app_len)
                phase = fpsc_pkg::PH_SIG_HDR;
            return;
        end
        if (sig_count >= fpsc_pkg::SIG_LEN)
        begin
            st = fpsc_pkg::ST_FORMAT;
            return;
        end
        sig_count++;
        sig_crc = crc_step(sig_crc, b);
    endtask

    task automatic finish_image(inout fpsc_pkg::result_t r, output logic [2:0] st);
        if (pkg_count != pkg_len || phase != fpsc_pkg::PH_SIG_DATA
            || sig_count != fpsc_pkg::SIG_LEN || app_count != app_len)
        begin
            st = fpsc_pkg::ST_INCOMPLETE;
            return;
        end
        if (pend_cnt != 0)
            flush_word(r);
        if (~sig_crc != sig_crc_exp || ~app_crc != app_crc_exp)
        begin
            st = fpsc_pkg::ST_CHECKSUM;
            return;
        end
        r.image_accepted = 1'b1;
        phase = fpsc_pkg::PH_IDLE;
        st = fpsc_pkg::ST_OK;
    endtask

    task automatic predict(input logic [1:0] act, input logic [7:0] b,
                           output fpsc_pkg::result_t r);
        logic [2:0] st;
        bit         open;
        r = '0;
        open = phase == fpsc_pkg::PH_APP_HDR || phase == fpsc_pkg::PH_APP_DATA
               || phase == fpsc_pkg::PH_SIG_HDR || phase == fpsc_pkg::PH_SIG_DATA;
        if (act == fpsc_pkg::ACT_START)
        begin
            clear_session();
            if (pkg_len < fpsc_pkg::MIN_PKG || !fits(target, 64'(WORD_BYTES)))
                st = fpsc_pkg::ST_FORMAT;
            else
            begin
                phase = fpsc_pkg::PH_APP_HDR;
                st = fpsc_pkg::ST_OK;
            end
        end
        else if ((act != fpsc_pkg::ACT_BYTE && act != fpsc_pkg::ACT_FINAL) || !open)
            st = fpsc_pkg::ST_STATE;
        else
        begin
            if (act == fpsc_pkg::ACT_BYTE)
                take_byte(b, r, st);
            else
                finish_image(r, st);
            if (st != fpsc_pkg::ST_OK)
                phase = fpsc_pkg::PH_FAILED;
        end
        r.status = st;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fpsc_pkg::result_t exp_r;
        if (!rst_n)
        begin
            pkg_len      = 0;
            target       = 0;
            region_start = 0;
            region_size  = 0;
            clear_session();
            expected_q.delete();
            fail_count      = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing expected (status %0d)", status);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    check_field("status", 64'(exp_r.status), 64'(status));
                    check_field("write_valid", 64'(exp_r.write_valid), 64'(write_valid));
                    check_field("flash_address", 64'(exp_r.flash_address),
                                64'(flash_address));
                    check_field("write_data", exp_r.write_data, write_data);
                    check_field("write_count", 64'(exp_r.write_count), 64'(write_count));
                    check_field("image_accepted", 64'(exp_r.image_accepted),
                                64'(image_accepted));
                end
            end
            if (in_valid && in_ready)
            begin
                predict(action, data_byte, exp_r);
                expected_q.push_back(exp_r);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fpsc_pkg::CFG_PKG_LEN: pkg_len      = cfg_data;
                    fpsc_pkg::CFG_TARGET:  target       = cfg_data;
                    fpsc_pkg::CFG_RSTART:  region_start = cfg_data;
                    fpsc_pkg::CFG_RSIZE:   region_size  = cfg_data;
                    default: ;
                endcase
            end
            pending_results = expected_q.size();
        end
    end

endmodule

@@ verif/tb_firmware_package_stream_checker.sv @@
// ----------------------------------------------------------------------------
// tb_firmware_package_stream_checker
// Drives start, byte and finalize words into the package checker: a short
// directed opening, then whole packages, mostly well formed, some broken.
// ----------------------------------------------------------------------------
module tb_firmware_package_stream_checker;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block must refuse as an invalid state.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = fpsc_pkg::ACT_START;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic        write_valid;
    logic [31:0] flash_address;
    logic [63:0] write_data;
    logic [3:0]  write_count;
    logic        image_accepted;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = fpsc_pkg::CFG_PKG_LEN;
    logic [31:0] cfg_data = 32'd0;

    int          fail_count;
    int          pending_results;

    // Idle knobs in percent (sender per word, receiver per cycle), changed as the run advances.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_asks = 0;
    int          words_sent = 0;
    int          sessions = 0;
    int          accepted_images = 0;

    logic [7:0]  pkg_bytes [$];

    firmware_package_stream_checker i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .write_valid    (write_valid),
        .flash_address  (flash_address),
        .write_data     (write_data),
        .write_count    (write_count),
        .image_accepted (image_accepted),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    fpsc_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .write_valid     (write_valid),
        .flash_address   (flash_address),
        .write_data      (write_data),
        .write_count     (write_count),
        .image_accepted  (image_accepted),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #50ms;
        $display("FAIL firmware_package_stream_checker");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request, counted
    // here so the sender keeps pushing words while the output is blocked.
    always @(negedge clk)
    begin
        int hold_served;
        int hold_left;
        if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Rotate through the idle profiles, one per quarter of the run.
    task automatic set_profile();
        case ((words_sent / 190) % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 49;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 49;
            end
            default:
            begin
                send_idle_pct  = 16;
                recv_stall_pct = 16;
            end
        endcase
    endtask

    // Offer one word and hold it until taken; then drop valid and maybe idle.
    task automatic send_word(input logic [1:0] act, input logic [7:0] b);
        in_valid  = 1'b1;
        action    = act;
        data_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        set_profile();
        @(negedge clk);
        in_valid = 1'b0;
        if ($urandom_range(0, 99) < send_idle_pct)
            repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    // Let every expected result come back, then cover the pipeline depth.
    task automatic drain();
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_regs(input logic [31:0] plen, input logic [31:0] tgt,
                             input logic [31:0] rstart, input logic [31:0] rsize);
        drain();
        write_reg(fpsc_pkg::CFG_PKG_LEN, plen);
        write_reg(fpsc_pkg::CFG_TARGET, tgt);
        write_reg(fpsc_pkg::CFG_RSTART, rstart);
        write_reg(fpsc_pkg::CFG_RSIZE, rsize);
    endtask

    function automatic logic [31:0] crc_of(input int first, input int count);
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        for (int n = first; n < first + count; n++)
        begin
            c ^= {24'd0, pkg_bytes[n]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        end
        return ~c;
    endfunction

    function automatic void put_le32(input int at, input logic [31:0] v);
        for (int k = 0; k < 4; k++)
            pkg_bytes[at + k] = v[8 * k +: 8];
    endfunction

    // Lay out a well-formed package: app header, app bytes, sig header, sig bytes.
    task automatic build_package(input int app_n);
        int sig_at;
        pkg_bytes.delete();
        repeat (276 + app_n) pkg_bytes.push_back(8'($urandom));
        sig_at = 10 + app_n;
        pkg_bytes[0] = fpsc_pkg::APP_ID[7:0];
        pkg_bytes[1] = fpsc_pkg::APP_ID[15:8];
        put_le32(2, app_n);
        put_le32(6, crc_of(10, app_n));
        pkg_bytes[sig_at]     = fpsc_pkg::SIG_ID[7:0];
        pkg_bytes[sig_at + 1] = fpsc_pkg::SIG_ID[15:8];
        put_le32(sig_at + 2, fpsc_pkg::SIG_LEN);
        put_le32(sig_at + 6, crc_of(sig_at + 10, 256));
    endtask

    // One download: 0-5 clean, 6 corrupted payload, 7 bad header or config,
    // 8 finalize too early, 9 one byte past the announced length. The last
    // session is cut short to keep the run near its word budget.
    task automatic run_session(input int kind);
        int          app_n;
        int          aligned;
        int          off;
        int          cut;
        logic [31:0] rstart;
        logic [31:0] rsize;
        logic [31:0] plen;
        app_n   = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        aligned = (app_n + 7) / 8 * 8;
        off     = $urandom_range(0, 64);
        rstart  = $urandom_range(0, 32'h7FFF_FFFF);
        rsize   = off + aligned + $urandom_range(0, 64);
        plen    = 276 + app_n;
        build_package(app_n);
        cut = pkg_bytes.size();
        case (kind)
            6: pkg_bytes[$urandom_range(10, plen - 1)] ^= 8'(1 << $urandom_range(0, 7));
            7:
            begin
                case ($urandom_range(0, 4))
                    0: pkg_bytes[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
                    1: plen += 1;
                    2: rsize = off + aligned - 1;
                    3: pkg_bytes[10 + app_n + 2] ^= 8'h01;
                    default: pkg_bytes[10 + app_n] ^= 8'h80;
                endcase
            end
            8: cut = $urandom_range(0, pkg_bytes.size() - 1);
            9:
            begin
                pkg_bytes.push_back(8'($urandom));
                cut++;
            end
            default: ;
        endcase
        if (words_sent + cut + 2 > 760)
            cut = (760 - words_sent - 2 > 0) ? 760 - words_sent - 2 : 0;
        load_regs(plen, rstart + off, rstart, rsize);
        if (sessions == 1)
            hold_asks++;
        send_word(fpsc_pkg::ACT_START, 8'($urandom));
        for (int n = 0; n < cut; n++)
        begin
            // Now and then slip in a stray word; it is refused and the session goes on.
            if ($urandom_range(0, 999) == 0)
                send_word(ACT_UNUSED, 8'($urandom));
            send_word(fpsc_pkg::ACT_BYTE, pkg_bytes[n]);
        end
        send_word(fpsc_pkg::ACT_FINAL, 8'($urandom));
        if (kind <= 5 && cut == pkg_bytes.size())
            accepted_images++;
        if ($urandom_range(0, 3) == 0)
            send_word(2'($urandom_range(1, 3)), 8'($urandom));
        sessions++;
    endtask

    initial
    begin
        int wait_cycles;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Idle session: every non-start word is refused; empty length fails start.
        send_word(fpsc_pkg::ACT_BYTE, 8'h00);
        send_word(fpsc_pkg::ACT_FINAL, 8'hFF);
        send_word(ACT_UNUSED, 8'hFF);
        send_word(fpsc_pkg::ACT_START, 8'h00);

        // Target at the very top of the address space, region to the last byte.
        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_word(fpsc_pkg::ACT_START, 8'hFF);
        // App header with zero size: format error, then the session is latched.
        send_word(fpsc_pkg::ACT_BYTE, fpsc_pkg::APP_ID[7:0]);
        send_word(fpsc_pkg::ACT_BYTE, fpsc_pkg::APP_ID[15:8]);
        repeat (4) send_word(fpsc_pkg::ACT_BYTE, 8'h00);
        repeat (4) send_word(fpsc_pkg::ACT_BYTE, 8'hFF);
        send_word(fpsc_pkg::ACT_BYTE, 8'h55);
        send_word(fpsc_pkg::ACT_FINAL, 8'h00);
        // Restart, then finalize straight away: incomplete.
        send_word(fpsc_pkg::ACT_START, 8'h00);
        send_word(fpsc_pkg::ACT_FINAL, 8'h00);

        // First write word would run past 2^32.
        load_regs(32'd276, 32'hFFFF_FFF9, 32'd0, 32'hFFFF_FFFF);
        send_word(fpsc_pkg::ACT_START, 8'h00);

        // Random packages while the idle profiles rotate.
        while (words_sent < 750)
            run_session($urandom_range(0, 9));

        wait_cycles = 0;
        while (pending_results != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (10) @(negedge clk);

        $display("Covered %0d words over %0d packages (%0d meant to pass), plus refusals,",
                 words_sent, sessions, accepted_images);
        $display("range and header faults, early finalize, overrun and CRC corruption.");
        if (fail_count == 0 && pending_results == 0)
            $display("PASS firmware_package_stream_checker");
        else
            $display("FAIL firmware_package_stream_checker");
        $finish;
    end

endmodule

@@ firmware_package_stream_checker.f @@
hw/rtl/fpsc_pkg.sv
hw/rtl/fpsc_core.sv
hw/rtl/firmware_package_stream_checker.sv
verif/fpsc_result_checker.sv
verif/tb_firmware_package_stream_checker.sv
